[rtl/core/register_script_line_parser_defines.svh]
// Assertion macros for the register script line parser.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef REGISTER_SCRIPT_LINE_PARSER_DEFINES_SVH
`define REGISTER_SCRIPT_LINE_PARSER_DEFINES_SVH

// Plain property, sampled on clk, off during reset.
`define RSLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define RSLP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RSLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rslp_pkg.sv]
// Shared types, constants and hex decode for the register script line parser.
// No dependencies.
package rslp_pkg;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_C = 8'h43;
    localparam logic [7:0] CH_LOWER_C = 8'h63;

    localparam logic [7:0] BANK_SEL_RESET  = 8'h01;
    localparam logic [7:0] CLOSING_DATA    = 8'h00;
    localparam logic [3:0] MIN_DIRECTIVE_LEN = 4'd8;

    // Result queue holds three results.
    localparam int         QUEUE_DEPTH = 3;

    typedef enum logic [7:0] {
        PH_LINE_START = 8'b0000_0001,
        PH_GOT_A      = 8'b0000_0010,
        PH_GOT_C      = 8'b0000_0100,
        PH_ADDR_WS    = 8'b0000_1000,
        PH_ADDR_LO    = 8'b0001_0000,
        PH_DATA_WS    = 8'b0010_0000,
        PH_DATA_LO    = 8'b0100_0000,
        PH_SKIP       = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] write_address;
        logic [7:0] write_data;
        logic       closing_write;
        logic       last_of_run;
    } result_t;

    // Results produced by one accepted character (count 0..2).
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    typedef struct packed {
        logic [1:0] count;
    } queue_status_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        case (c) inside
            [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
            [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
            [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
            default:       r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/rslp_parser.sv]
// Line grammar state machine: one character per accepted beat, up to two results.
// Depends on rslp_pkg.
module rslp_parser
    import rslp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] text_char,
    input  logic       end_of_text,
    input  logic [7:0] bank_sel,
    output push_t      push
);

    phase_t     phase_reg, phase_next;
    logic [7:0] addr_reg, addr_next;
    logic [3:0] dhi_reg, dhi_next;
    logic [3:0] cnt_reg, cnt_next;

    logic [4:0] hx;
    logic       hx_ok;
    logic       blank;
    logic       in_dir;
    logic [3:0] cnt_inc;
    phase_t     miss;
    logic       emit_dir;
    result_t    dir_res;
    result_t    close_res;

    always_comb
    begin
        hx      = hex_decode(text_char);
        hx_ok   = hx[4];
        blank   = (text_char == CH_SPACE) || (text_char == CH_TAB);
        miss    = (text_char == CH_NL) ? PH_LINE_START : PH_SKIP;
        in_dir  = (phase_reg == PH_GOT_A)   || (phase_reg == PH_GOT_C)   ||
                  (phase_reg == PH_ADDR_WS) || (phase_reg == PH_ADDR_LO) ||
                  (phase_reg == PH_DATA_WS) || (phase_reg == PH_DATA_LO);
        cnt_inc = (in_dir && (cnt_reg < MIN_DIRECTIVE_LEN)) ? cnt_reg + 4'd1 : cnt_reg;

        phase_next = phase_reg;
        addr_next  = addr_reg;
        dhi_next   = dhi_reg;
        cnt_next   = cnt_inc;
        emit_dir   = 1'b0;

        case (phase_reg)
            PH_LINE_START:
            begin
                if (blank)
                begin
                    phase_next = PH_LINE_START;
                end
                else if ((text_char == CH_UPPER_A) || (text_char == CH_LOWER_A))
                begin
                    cnt_next   = 4'd1;
                    phase_next = PH_GOT_A;
                end
                else
                begin
                    phase_next = miss;
                end
            end
            PH_GOT_A:
            begin
                phase_next = ((text_char == CH_UPPER_C) || (text_char == CH_LOWER_C)) ?
                             PH_GOT_C : miss;
            end
            PH_GOT_C:
            begin
                phase_next = (text_char == CH_SPACE) ? PH_ADDR_WS : miss;
            end
            PH_ADDR_WS:
            begin
                if (blank)
                begin
                    phase_next = PH_ADDR_WS;
                end
                else if (hx_ok)
                begin
                    addr_next  = {4'd0, hx[3:0]};
                    phase_next = PH_ADDR_LO;
                end
                else
                begin
                    phase_next = miss;
                end
            end
            PH_ADDR_LO:
            begin
                if (hx_ok)
                begin
                    addr_next  = {addr_reg[3:0], hx[3:0]};
                    phase_next = PH_DATA_WS;
                end
                else
                begin
                    phase_next = miss;
                end
            end
            PH_DATA_WS:
            begin
                if (blank)
                begin
                    phase_next = PH_DATA_WS;
                end
                else if (hx_ok)
                begin
                    dhi_next   = hx[3:0];
                    phase_next = PH_DATA_LO;
                end
                else
                begin
                    phase_next = miss;
                end
            end
            PH_DATA_LO:
            begin
                if (hx_ok)
                begin
                    // short directive at end of text is dropped
                    emit_dir   = !end_of_text || (cnt_inc >= MIN_DIRECTIVE_LEN);
                    phase_next = PH_SKIP;
                end
                else
                begin
                    phase_next = miss;
                end
            end
            default:
            begin
                phase_next = (text_char == CH_NL) ? PH_LINE_START : PH_SKIP;
            end
        endcase

        dir_res.write_address = addr_reg;
        dir_res.write_data    = {dhi_reg, hx[3:0]};
        dir_res.closing_write = 1'b0;
        dir_res.last_of_run   = !end_of_text;

        close_res.write_address = bank_sel;
        close_res.write_data    = CLOSING_DATA;
        close_res.closing_write = 1'b1;
        close_res.last_of_run   = 1'b1;

        if (end_of_text)
        begin
            phase_next = PH_LINE_START;
            addr_next  = 8'd0;
            dhi_next   = 4'd0;
            cnt_next   = 4'd0;
        end

        push.res0  = emit_dir ? dir_res : close_res;
        push.res1  = close_res;
        push.count = !accept ? 2'd0 :
                     (emit_dir && end_of_text) ? 2'd2 :
                     (emit_dir || end_of_text) ? 2'd1 : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE_START;
            addr_reg  <= 8'd0;
            dhi_reg   <= 4'd0;
            cnt_reg   <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            dhi_reg   <= dhi_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[rtl/core/rslp_result_queue.sv]
// Three-entry shifting result queue; head is entry 0 and drives the output.
// Depends on rslp_pkg.
module rslp_result_queue
    import rslp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    input  logic          pop,
    output result_t       head,
    output queue_status_t status
);

    result_t    ent_reg  [QUEUE_DEPTH];
    result_t    ent_next [QUEUE_DEPTH];
    logic [1:0] count_reg, count_next;
    logic [1:0] base;

    always_comb
    begin
        base = count_reg - {1'b0, pop};
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i < QUEUE_DEPTH - 1))
                ent_next[i] = ent_reg[i + 1];
            else
                ent_next[i] = ent_reg[i];
            if ((push.count != 2'd0) && (base == 2'(i)))
                ent_next[i] = push.res0;
            else if ((push.count == 2'd2) && ((base + 2'd1) == 2'(i)))
                ent_next[i] = push.res1;
        end
        count_next = base + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            ent_reg[i] <= ent_next[i];
    end

    assign head         = ent_reg[0];
    assign status.count = count_reg;

endmodule

[rtl/core/register_script_line_parser.sv]
// Top level of the register script line parser: config register, parser, result queue.
// Depends on rslp_pkg, rslp_parser, rslp_result_queue and the defines header.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_ready  | text_char, end_of_text
//   output   | out_valid / out_ready| write_address, write_data, closing_write,
//            |                      | last_of_run
//   config   | cfg_we               | cfg_data (bank_select_address)
//
// One character is taken per cycle while in_ready is high; its results are in
// the queue the next cycle. A character yields zero, one or two results; the
// parser state machine never stalls a beat. The three-entry result queue sets
// the pace: in_ready is high while at most one result stays queued after this
// cycle's pop, so the second result of an end-of-text beat needs its own output beat.
// Reset clears the parse state and the queue count; bank_select_address resets to 1.
`include "register_script_line_parser_defines.svh"

module register_script_line_parser
    import rslp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_char,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] write_address,
    output logic [7:0] write_data,
    output logic       closing_write,
    output logic       last_of_run,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);

    logic [7:0]    bank_sel_reg;
    logic          in_beat;
    logic          out_beat;
    push_t         push;
    result_t       head;
    queue_status_t q_status;

    // Bank select address for the closing write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bank_sel_reg <= BANK_SEL_RESET;
        else if (cfg_we)
            bank_sel_reg <= cfg_data;
    end

    assign out_valid = (q_status.count != 2'd0);
    assign out_beat  = out_valid && out_ready;
    // Room for two results after this cycle's pop.
    assign in_ready  = (q_status.count <= 2'd1) || ((q_status.count == 2'd2) && out_ready);
    assign in_beat   = in_valid && in_ready;

    rslp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_beat),
        .text_char   (text_char),
        .end_of_text (end_of_text),
        .bank_sel    (bank_sel_reg),
        .push        (push)
    );

    rslp_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (out_beat),
        .head   (head),
        .status (q_status)
    );

    assign write_address = head.write_address;
    assign write_data    = head.write_data;
    assign closing_write = head.closing_write;
    assign last_of_run   = head.last_of_run;

    // Closing write always ends its run.
    `RSLP_ASSERT_IMPLY(a_close_is_last, out_valid && closing_write, last_of_run, "closing write not last")
    // End of text always leaves a result to deliver.
    `RSLP_ASSERT_NEXT(a_eot_gives_result, in_beat && end_of_text, out_valid, "no result after end of text")
    // A result that is not last has its partner queued behind it.
    `RSLP_ASSERT_IMPLY(a_pair_queued, out_valid && !last_of_run, q_status.count >= 2'd2, "pair split")
    // Queue never wraps to empty from full.
    `RSLP_ASSERT_NEXT(a_no_wrap, q_status.count == 2'd3, q_status.count != 2'd0, "queue count wrapped")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for register_script_line_parser: script stimulus, random stalls.
// Depends on rslp_pkg and the register_script_line_parser RTL.
module tb_top;
    import rslp_pkg::*;

    // Generous cycle budget for the whole run.
    localparam int CYCLE_LIMIT  = 400000;
    // Cycles to let the block settle once nothing is expected.
    localparam int SETTLE_WAIT  = 8;
    localparam int PHASE_CHARS  = 175;
    localparam int MAX_GAP      = 6;

    // Predicts register writes from the accepted character stream and holds them
    // until the block delivers them.
    class reg_write_scoreboard;
        phase_t     phase;
        logic [7:0] addr_acc;
        logic [3:0] data_hi;
        logic [3:0] dir_count;
        logic [7:0] bank_addr;
        result_t    pending_writes[$];
        int         errors;

        function new();
            bank_addr = BANK_SEL_RESET;
            errors    = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase     = PH_LINE_START;
            addr_acc  = '0;
            data_hi   = '0;
            dir_count = '0;
        endfunction

        function bit decode_hex(input logic [7:0] c, output logic [3:0] nib);
            nib = '0;
            if (c >= "0" && c <= "9") nib = 4'(c - "0");
            else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
            else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
            else return 1'b0;
            return 1'b1;
        endfunction

        function bit is_blank(input logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB;
        endfunction

        // Newline starts a fresh line, anything else skips to the next one.
        function phase_t on_mismatch(input logic [7:0] c);
            return (c == CH_NL) ? PH_LINE_START : PH_SKIP;
        endfunction

        // One accepted beat: advance the parse and queue its writes.
        function void note_char(input logic [7:0] c, input logic eot);
            logic [3:0] nib;
            bit         hex;
            result_t    batch[$];
            hex = decode_hex(c, nib);

            if (phase != PH_LINE_START && phase != PH_SKIP &&
                dir_count < MIN_DIRECTIVE_LEN)
                dir_count++;

            case (phase)
                PH_LINE_START:
                begin
                    if (is_blank(c))
                    begin
                        // stay
                    end
                    else if (c == CH_UPPER_A || c == CH_LOWER_A)
                    begin
                        dir_count = 4'd1;
                        phase     = PH_GOT_A;
                    end
                    else phase = on_mismatch(c);
                end
                PH_GOT_A:
                    phase = (c == CH_UPPER_C || c == CH_LOWER_C) ? PH_GOT_C : on_mismatch(c);
                PH_GOT_C:
                    phase = (c == CH_SPACE) ? PH_ADDR_WS : on_mismatch(c);
                PH_ADDR_WS:
                begin
                    if (is_blank(c))
                    begin
                        // stay
                    end
                    else if (hex)
                    begin
                        addr_acc = {4'd0, nib};
                        phase    = PH_ADDR_LO;
                    end
                    else phase = on_mismatch(c);
                end
                PH_ADDR_LO:
                begin
                    if (hex)
                    begin
                        addr_acc = {addr_acc[3:0], nib};
                        phase    = PH_DATA_WS;
                    end
                    else phase = on_mismatch(c);
                end
                PH_DATA_WS:
                begin
                    if (is_blank(c))
                    begin
                        // stay
                    end
                    else if (hex)
                    begin
                        data_hi = nib;
                        phase   = PH_DATA_LO;
                    end
                    else phase = on_mismatch(c);
                end
                PH_DATA_LO:
                begin
                    if (hex)
                    begin
                        // short directive right at end of text is dropped
                        if (!eot || dir_count >= MIN_DIRECTIVE_LEN)
                            batch.push_back('{addr_acc, {data_hi, nib}, 1'b0, 1'b0});
                        phase = PH_SKIP;
                    end
                    else phase = on_mismatch(c);
                end
                default:
                    phase = (c == CH_NL) ? PH_LINE_START : PH_SKIP;
            endcase

            if (eot)
            begin
                batch.push_back('{bank_addr, CLOSING_DATA, 1'b1, 1'b0});
                clear_parse();
            end

            if (batch.size() > 0)
                batch[batch.size() - 1].last_of_run = 1'b1;
            foreach (batch[i])
                pending_writes.push_back(batch[i]);
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_write(input result_t got);
            result_t want;
            if (pending_writes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected write addr=%02h data=%02h",
                                          got.write_address, got.write_data));
                return;
            end
            want = pending_writes.pop_front();
            if (got.write_address !== want.write_address)
                report_mismatch($sformatf("write_address got %02h want %02h",
                                          got.write_address, want.write_address));
            if (got.write_data !== want.write_data)
                report_mismatch($sformatf("write_data got %02h want %02h",
                                          got.write_data, want.write_data));
            if (got.closing_write !== want.closing_write)
                report_mismatch($sformatf("closing_write got %b want %b",
                                          got.closing_write, want.closing_write));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run got %b want %b",
                                          got.last_of_run, want.last_of_run));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] text_char;
    logic       end_of_text;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] write_address;
    logic [7:0] write_data;
    logic       closing_write;
    logic       last_of_run;
    logic       cfg_we;
    logic [7:0] cfg_data;

    reg_write_scoreboard sb;
    logic [7:0]          script_bytes[$];
    int                  chars_in_phase;
    int                  send_max_gap;
    int                  recv_max_gap;
    int                  cycle_count;

    register_script_line_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_char     (text_char),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_address (write_address),
        .write_data    (write_data),
        .closing_write (closing_write),
        .last_of_run   (last_of_run),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Monitor: both channels are sampled at the edge, before any drive update lands.
    // A result accepted here always stems from an earlier input beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_write('{write_address, write_data, closing_write, last_of_run});
            if (in_valid && in_ready)
                sb.note_char(text_char, end_of_text);
        end
    end

    // Receiver: a random stall before each beat, bounded by recv_max_gap; the bound is
    // re-drawn every 40 beats between stalling (MAX_GAP) and streaming (zero).
    initial
    begin
        int gap;
        int beats;
        out_ready    = 1'b0;
        recv_max_gap = MAX_GAP;
        beats        = 0;
        forever
        begin
            gap = $urandom_range(0, recv_max_gap);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            beats++;
            if (beats % 40 == 0)
                recv_max_gap = $urandom_range(0, 1) ? MAX_GAP : 0;
        end
    end

    // ---- script text builders -------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 10)
            return 8'("0") + 8'(nib);
        return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
    endfunction

    function automatic void add_blank();
        script_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void add_hex_byte(input logic [7:0] v);
        script_bytes.push_back(hex_char(v[7:4]));
        script_bytes.push_back(hex_char(v[3:0]));
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            script_bytes.push_back(s[i]);
    endfunction

    // Well-formed "Ac HH HH"; tight form has no optional blanks (7 bytes from 'A').
    function automatic void add_directive(input bit tight);
        if (!tight) repeat ($urandom_range(0, 2)) add_blank();
        script_bytes.push_back($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A);
        script_bytes.push_back($urandom_range(0, 1) ? CH_UPPER_C : CH_LOWER_C);
        script_bytes.push_back(CH_SPACE);
        if (!tight) repeat ($urandom_range(0, 2)) add_blank();
        add_hex_byte(8'($urandom_range(0, 255)));
        if (!tight) repeat ($urandom_range(0, 2)) add_blank();
        add_hex_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_line();
        int kind;
        int start;
        int pos;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            add_directive(1'b0);
            // trailing text after a complete directive is ignored
            if ($urandom_range(0, 2) == 0)
            begin
                add_blank();
                repeat ($urandom_range(1, 4))
                    script_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
            end
        end
        else if (kind <= 7)
        begin
            // broken directive: one byte corrupted, or cut short
            start = script_bytes.size();
            add_directive(1'b0);
            pos = $urandom_range(start, script_bytes.size() - 1);
            if ($urandom_range(0, 1))
                script_bytes[pos] = 8'($urandom_range(0, 255));
            else
                while (script_bytes.size() > pos) void'(script_bytes.pop_back());
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(1, 8)) script_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3)) add_blank();
        end
        script_bytes.push_back(CH_NL);
    endfunction

    function automatic void build_script();
        if ($urandom_range(0, 9) == 0)
        begin
            script_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 5)) add_line();
        // directive cut off by end of text, tight form is the short case
        if ($urandom_range(0, 2) == 0)
            add_directive(1'($urandom_range(0, 1)));
    endfunction

    // ---- drivers ----------------------------------------------------------

    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = $urandom_range(0, send_max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_char   <= c;
        end_of_text <= eot;
        do @(posedge clk); while (!in_ready);
    endtask

    // Whole script; end_of_text rides on its last byte.
    task automatic send_script();
        send_max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
        for (int i = 0; i < script_bytes.size(); i++)
            send_char(script_bytes[i], i == script_bytes.size() - 1);
        chars_in_phase += script_bytes.size();
        script_bytes.delete();
    endtask

    // Hold off the sender until every expected write has come back, then settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_writes.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_bank(input logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        sb.bank_addr = v;
    endtask

    // ---- main sequence ----------------------------------------------------

    initial
    begin
        logic [7:0] bank_values[4];
        in_valid    = 1'b0;
        text_char   = '0;
        end_of_text = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        sb          = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, bank address still at its reset value:
        // leading tab and mixed case, newline inside a directive,
        // short directive dropped at end of text.
        send_max_gap = MAX_GAP;
        add_text("\taC fF 0a\nAc 5\nAc 1234");
        send_script();
        // extreme byte values, closing write alone
        script_bytes.push_back(8'h00);
        script_bytes.push_back(8'hFF);
        send_script();

        bank_values[0] = 8'h00;
        bank_values[1] = 8'hFF;
        bank_values[2] = 8'($urandom_range(2, 254));
        bank_values[3] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_bank(bank_values[p]);
            chars_in_phase = 0;
            while (chars_in_phase < PHASE_CHARS)
            begin
                build_script();
                send_script();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.pending_writes.size() != 0)
            sb.report_mismatch($sformatf("%0d writes never arrived", sb.pending_writes.size()));
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rslp_pkg.sv
rtl/core/rslp_parser.sv
rtl/core/rslp_result_queue.sv
rtl/core/register_script_line_parser.sv
sim/tb_top.sv
